// File: sv/mpsq_pkg.sv
// ----------------------------------------------------------------------------
// mpsq_pkg: shared types and constants for the multiprecision squarer
// Holds the sequencer state type, the control word that travels down the
// multiply-accumulate pipeline, and the fixed port widths.
// ----------------------------------------------------------------------------
`default_nettype none

package mpsq_pkg;

   // Fixed widths of the request and result ports.
   localparam int REQ_LIMB_W = 32;
   localparam int REQ_SIGN_W = 2;
   localparam int RSP_LIMB_W = 32;

   // A limb is split into at most two multiplier digits of up to 32 bits.
   localparam int MUL_DIG_W = 32;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_ISSUE,
      ST_EOC,
      ST_DRAIN
   } mpsq_state_type;

   // One pipeline slot: either a partial product or an end-of-column token.
   typedef struct packed {
      logic valid;
      logic dbl;    // cross product, counted twice
      logic eoc;    // end of column: emit the low limb and shift
      logic last;   // final column of the square
      logic da;     // digit select of the first operand
      logic db;     // digit select of the second operand
   } mpsq_ctrl_type;

endpackage : mpsq_pkg

`default_nettype wire

// File: sv/mpsq_mac.sv
// ----------------------------------------------------------------------------
// mpsq_mac: shared multiplier and column accumulator
// Multiplies one digit pair per cycle, adds it into the column accumulator
// at its weight, and on an end-of-column token emits the low limb.
// ----------------------------------------------------------------------------
`default_nettype none

module mpsq_mac
   import mpsq_pkg::*;
#(
   parameter int LIMB_BITS = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire mpsq_ctrl_type         ctrl,
   input  wire logic [LIMB_BITS-1:0]  op_a,
   input  wire logic [LIMB_BITS-1:0]  op_b,
   output logic                       done,
   output logic                       rsp_strobe,
   output logic [RSP_LIMB_W-1:0]      rsp_result_limb,
   output logic                       rsp_result_last
);

   localparam int NUM_DIG = (LIMB_BITS + MUL_DIG_W - 1) / MUL_DIG_W;
   localparam int DIG_W   = (LIMB_BITS + NUM_DIG - 1) / NUM_DIG;
   localparam int PROD_W  = 2 * DIG_W;
   localparam int SH_W    = $clog2(2 * DIG_W + 2);
   // A column holds its doubled products plus the carry in, with eight bits of headroom above two limbs.
   localparam int ACC_W   = 2 * LIMB_BITS + 8;

   logic [DIG_W-1:0]      dig_a;
   logic [DIG_W-1:0]      dig_b;
   logic [SH_W-1:0]       shamt;

   logic [PROD_W-1:0]     prod_ff;
   logic [SH_W-1:0]       shamt_ff;
   logic                  valid_ff;
   logic                  eoc_ff;
   logic                  last_ff;

   logic [ACC_W-1:0]      acc_ff;
   logic [ACC_W-1:0]      acc_in;
   logic                  strobe_ff;
   logic [RSP_LIMB_W-1:0] limb_ff;
   logic                  rlast_ff;

   // Multiply stage.
   always_comb begin
      dig_a = ctrl.da ? DIG_W'(op_a >> DIG_W) : DIG_W'(op_a);
      dig_b = ctrl.db ? DIG_W'(op_b >> DIG_W) : DIG_W'(op_b);
      shamt = SH_W'(ctrl.da ? DIG_W : 0) + SH_W'(ctrl.db ? DIG_W : 0) + SH_W'(ctrl.dbl);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= ctrl.valid;
      end
      eoc_ff   <= ctrl.eoc;
      last_ff  <= ctrl.last;
      prod_ff  <= PROD_W'(dig_a) * PROD_W'(dig_b);
      shamt_ff <= shamt;
   end

   // Accumulate stage.
   always_comb begin
      acc_in = acc_ff;
      if (valid_ff) begin
         if (eoc_ff) begin
            acc_in = acc_ff >> LIMB_BITS;
         end else begin
            acc_in = acc_ff + (ACC_W'(prod_ff) << shamt_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         acc_ff    <= acc_in;
         strobe_ff <= valid_ff & eoc_ff;
      end
      limb_ff  <= RSP_LIMB_W'(acc_ff[LIMB_BITS-1:0]);
      rlast_ff <= last_ff;
   end

   assign done            = valid_ff & eoc_ff & last_ff;
   assign rsp_strobe      = strobe_ff;
   assign rsp_result_limb = limb_ff;
   assign rsp_result_last = rlast_ff;

endmodule : mpsq_mac

`default_nettype wire

// File: sv/multiprecision_squarer.sv
// ----------------------------------------------------------------------------
// multiprecision_squarer: schoolbook squaring of a multi-limb integer
// Collects operand limbs, then forms the exact square column by column on
// one shared multiplier and streams out the result limbs.
// ----------------------------------------------------------------------------
// Usage. Operand limbs arrive as requests on req_limb, least significant
// first, one per cycle if desired; a request is taken when start is high and
// busy is low. The request with req_is_last set closes the operand and its
// req_sign gives the sign. Limbs beyond MAX_LIMBS are dropped and flagged on
// rsp_overflow of the whole result run.
// After the last request busy rises and the square is formed by product
// scanning: for each result column every digit product x[i]*x[j], i <= j,
// goes through the one multiplier (cross products counted twice), then a
// column token emits the low limb of the accumulator and shifts it down.
// With n limbs and D multiplier digits per limb (D is 1 up to 32-bit limbs,
// 2 above) the closing request is followed by D*D*n*(n+1)/2 digit products
// and 2n column tokens, one digit product or column token per cycle, through
// the multiply and accumulate stages. The 2n result limbs appear
// on rsp_result_limb, each for one cycle with rsp_strobe, with
// rsp_result_last on the final one. The receiver cannot stall the block.
// busy falls with the last result, and new requests may follow at once.
// Reset clears the state, limb count, pending overflow flag and pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module multiprecision_squarer
   import mpsq_pkg::*;
#(
   parameter int LIMB_BITS = 32,
   parameter int MAX_LIMBS = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [REQ_LIMB_W-1:0]         req_limb,
   input  wire logic                          req_is_last,
   input  wire logic signed [REQ_SIGN_W-1:0]  req_sign,
   output logic                               rsp_strobe,
   output logic [RSP_LIMB_W-1:0]              rsp_result_limb,
   output logic                               rsp_result_last,
   output logic                               rsp_result_sign,
   output logic                               rsp_overflow
);

   localparam int NUM_DIG = (LIMB_BITS + MUL_DIG_W - 1) / MUL_DIG_W;
   localparam int IDX_W   = (MAX_LIMBS > 1) ? $clog2(MAX_LIMBS) : 1;
   localparam int CNT_W   = $clog2(MAX_LIMBS + 1);
   localparam int COL_W   = (MAX_LIMBS > 1) ? $clog2(2 * MAX_LIMBS) : 1;

   // Sequencer and run state.
   mpsq_state_type      state_ff, state_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                ovf_seen_ff, ovf_seen_in;
   logic [CNT_W-1:0]    n_ff, n_in;
   logic                run_sign_ff, run_sign_in;
   logic                run_ovf_ff, run_ovf_in;
   logic [COL_W-1:0]    k_ff, k_in;
   logic [IDX_W-1:0]    i_ff, i_in;
   logic [IDX_W-1:0]    j_ff, j_in;
   logic                da_ff, da_in;
   logic                db_ff, db_in;

   // Operand store and the read stage in front of the multiplier.
   logic [LIMB_BITS-1:0] opstore_mem [MAX_LIMBS];
   logic                 wr_en;
   logic [LIMB_BITS-1:0] rd_a_ff;
   logic [LIMB_BITS-1:0] rd_b_ff;
   mpsq_ctrl_type        issue;
   mpsq_ctrl_type        ctrl_ff;

   // Helpers for the column walk.
   logic [CNT_W-1:0]    cnt_next;
   logic                ovf_now;
   logic [COL_W:0]      col_nx;
   logic [COL_W:0]      ilo_nx;
   logic [COL_W:0]      top_m1;
   logic                col_last;
   logic                pair_more;
   logic                mac_done;

   always_comb begin
      col_nx    = {1'b0, k_ff} + (COL_W+1)'(1);
      ilo_nx    = (col_nx < (COL_W+1)'(n_ff)) ? '0
                                              : col_nx - (COL_W+1)'(n_ff) + (COL_W+1)'(1);
      top_m1    = (COL_W+1)'({n_ff, 1'b0}) - (COL_W+1)'(1);
      col_last  = ({1'b0, k_ff} == top_m1);
      // Another pair (i+1, j-1) exists in this column while i+1 <= j-1.
      pair_more = ((IDX_W+1)'(i_ff) + (IDX_W+1)'(1)) < (IDX_W+1)'(j_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_LOAD;
         cnt_ff      <= '0;
         ovf_seen_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         ovf_seen_ff <= ovf_seen_in;
      end
      n_ff        <= n_in;
      run_sign_ff <= run_sign_in;
      run_ovf_ff  <= run_ovf_in;
      k_ff        <= k_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      da_ff       <= da_in;
      db_ff       <= db_in;
   end

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      ovf_seen_in = ovf_seen_ff;
      n_in        = n_ff;
      run_sign_in = run_sign_ff;
      run_ovf_in  = run_ovf_ff;
      k_in        = k_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      da_in       = da_ff;
      db_in       = db_ff;
      issue       = '0;
      wr_en       = 1'b0;
      cnt_next    = cnt_ff;
      ovf_now     = 1'b0;

      unique case (state_ff)
         ST_LOAD: begin
            if (start) begin
               if (cnt_ff < CNT_W'(MAX_LIMBS)) begin
                  wr_en    = 1'b1;
                  cnt_next = cnt_ff + CNT_W'(1);
               end else begin
                  ovf_now = 1'b1;
               end
               if (req_is_last) begin
                  n_in        = cnt_next;
                  cnt_in      = '0;
                  ovf_seen_in = 1'b0;
                  run_ovf_in  = ovf_seen_ff | ovf_now;
                  run_sign_in = (req_sign != '0);
                  k_in        = '0;
                  i_in        = '0;
                  j_in        = '0;
                  da_in       = 1'b0;
                  db_in       = 1'b0;
                  state_in    = ST_ISSUE;
               end else begin
                  cnt_in      = cnt_next;
                  ovf_seen_in = ovf_seen_ff | ovf_now;
               end
            end
         end
         ST_ISSUE: begin
            issue.valid = 1'b1;
            issue.dbl   = (i_ff != j_ff);
            issue.da    = da_ff;
            issue.db    = db_ff;
            if (db_ff != 1'(NUM_DIG - 1)) begin
               db_in = ~db_ff;
            end else begin
               db_in = 1'b0;
               if (da_ff != 1'(NUM_DIG - 1)) begin
                  da_in = ~da_ff;
               end else begin
                  da_in = 1'b0;
                  if (pair_more) begin
                     i_in = i_ff + IDX_W'(1);
                     j_in = j_ff - IDX_W'(1);
                  end else begin
                     state_in = ST_EOC;
                  end
               end
            end
         end
         ST_EOC: begin
            issue.valid = 1'b1;
            issue.eoc   = 1'b1;
            issue.last  = col_last;
            if (col_last) begin
               state_in = ST_DRAIN;
            end else begin
               k_in = COL_W'(col_nx);
               i_in = IDX_W'(ilo_nx);
               j_in = IDX_W'(col_nx - ilo_nx);
               // The top column has no products, only its token.
               if (col_nx != top_m1) begin
                  state_in = ST_ISSUE;
               end
            end
         end
         ST_DRAIN: begin
            if (mac_done) begin
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // Operand store: one write port, two registered read ports.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         opstore_mem[cnt_ff[IDX_W-1:0]] <= LIMB_BITS'(req_limb);
      end
      rd_a_ff <= opstore_mem[i_ff];
      rd_b_ff <= opstore_mem[j_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else begin
         ctrl_ff <= issue;
      end
   end

   mpsq_mac #(
      .LIMB_BITS (LIMB_BITS)
   ) u_mac (
      .clock           (clock),
      .reset           (reset),
      .ctrl            (ctrl_ff),
      .op_a            (rd_a_ff),
      .op_b            (rd_b_ff),
      .done            (mac_done),
      .rsp_strobe      (rsp_strobe),
      .rsp_result_limb (rsp_result_limb),
      .rsp_result_last (rsp_result_last)
   );

   assign busy            = (state_ff != ST_LOAD);
   assign rsp_result_sign = run_sign_ff;
   assign rsp_overflow    = run_ovf_ff;

   // A result only follows a cycle in which the block was squaring.
   a_rsp_in_run: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result emitted outside a squaring run");

   // The last result ends the run: nothing follows it.
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_result_last) |=> !rsp_strobe)
      else $error("result emitted after the last limb");

   // Products are only issued for pairs inside the operand, with i <= j.
   a_pair_ok: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ISSUE) |-> ((i_ff <= j_ff) && ((CNT_W+1)'(j_ff) < (CNT_W+1)'(n_ff))))
      else $error("product pair outside the operand");

   // A closing request always starts a squaring run.
   a_last_starts: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_is_last) |=> busy)
      else $error("closing request did not start squaring");

endmodule : multiprecision_squarer

`default_nettype wire
